### sv/fit_policy_block_allocator_unit_assert.svh
// Assertion macros used by the allocator RTL.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Clocked property, disabled while reset is asserted (active low).
`define FPBA_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression that must never be true on a clock edge.
`define FPBA_ASSERT_NEVER(name, clk, rstn, expr, msg) \
  `FPBA_ASSERT(name, clk, rstn, !(expr), msg)

`endif

### sv/fpba_pkg.sv
// Shared constants and types of the fit-policy block allocator.
package fpba_pkg;

  localparam int unsigned CMD_W      = 1;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned REQ_W      = 16;
  localparam int unsigned IDX_OUT_W  = 4;
  localparam int unsigned POLICY_W   = 2;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

  // Fit policy codes; the unused code behaves as first fit
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_FIT_POLICY  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_COUNT = 1'd1;

  localparam logic [POLICY_W-1:0] POLICY_RESET = POL_FIRST;
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 5'd16;

  typedef struct packed {
    logic                 granted;
    logic [IDX_OUT_W-1:0] block_index;
  } result_t;

endpackage

### sv/fpba_in_if.sv
// Input channel: load and allocate beats.
interface fpba_in_if;
  import fpba_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SLOT_W-1:0] block_slot;
  logic [REQ_W-1:0]  size_value;

  modport source (output valid, output command, output block_slot, output size_value,
                  input ready);
  modport sink (input valid, input command, input block_slot, input size_value,
                output ready);
endinterface

### sv/fpba_out_if.sv
// Output channel: allocation result beats.
interface fpba_out_if;
  import fpba_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 granted;
  logic [IDX_OUT_W-1:0] block_index;

  modport source (output valid, output granted, output block_index, input ready);
  modport sink (input valid, input granted, input block_index, output ready);
endinterface

### sv/fpba_ram.sv
// Remaining-size table: 1R1W synchronous RAM with per-entry valid bits.
module fpba_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] rdata_q;
  logic             rvalid_q;

  // Valid bits stand in for the reset-to-zero of the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

### sv/fpba_ctrl.sv
// Allocation sequencer: table scan, policy compare and write-back.
module fpba_ctrl #(
  parameter int unsigned NUM_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16,
  parameter int unsigned IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  fpba_in_if.sink                        in_if,
  input  logic [fpba_pkg::POLICY_W-1:0]  policy_i,
  input  logic [fpba_pkg::COUNT_W-1:0]   bcount_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output fpba_pkg::result_t              res_o,
  output logic                           mem_we_o,
  output logic [IDX_W-1:0]               mem_waddr_o,
  output logic [SIZE_BITS-1:0]           mem_wdata_o,
  output logic [IDX_W-1:0]               mem_raddr_o,
  input  logic [SIZE_BITS-1:0]           mem_rdata_i
);
  import fpba_pkg::*;

  `include "fit_policy_block_allocator_unit_assert.svh"

  localparam int unsigned CNT_W   = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned LIM_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int unsigned CMP_W   = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;
  localparam int unsigned SLOTC_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_DONE} state_e;

  state_e               state_q;
  logic [LIM_W-1:0]     rd_idx_q;
  logic                 chk_valid_q;
  logic [IDX_W-1:0]     chk_idx_q;
  logic                 found_q;
  logic [IDX_W-1:0]     pick_q;
  logic [SIZE_BITS-1:0] pick_val_q;
  logic [REQ_W-1:0]     req_q;

  logic [LIM_W-1:0]     bc_ext;
  logic [LIM_W-1:0]     limit;
  logic                 fits;
  logic                 take;
  logic                 slot_ok;
  logic                 alloc_acc;

  // Blocks searched: register value saturated at the table depth
  assign bc_ext = LIM_W'(bcount_i);
  assign limit  = (bc_ext > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS) : bc_ext;

  assign in_if.ready = (state_q == ST_IDLE);
  assign alloc_acc   = in_if.valid && (state_q == ST_IDLE) && (in_if.command == CMD_ALLOC);
  assign slot_ok     = SLOTC_W'(in_if.block_slot) < SLOTC_W'(NUM_BLOCKS);

  // Candidate compare on the entry read last cycle
  assign fits = CMP_W'(mem_rdata_i) >= CMP_W'(req_q);

  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!found_q) begin
        take = 1'b1;
      end else begin
        unique case (policy_i)
          POL_FIRST: take = 1'b0;
          POL_BEST:  take = mem_rdata_i < pick_val_q;
          POL_WORST: take = mem_rdata_i > pick_val_q;
          default:   take = 1'b0;
        endcase
      end
    end
  end

  // Single write port: loads in idle, write-back of the granted entry at result handoff
  always_comb begin
    if (state_q == ST_IDLE) begin
      mem_we_o    = in_if.valid && (in_if.command == CMD_LOAD) && slot_ok;
      mem_waddr_o = IDX_W'(in_if.block_slot);
      mem_wdata_o = SIZE_BITS'(in_if.size_value);
    end else begin
      mem_we_o    = (state_q == ST_DONE) && res_ready_i && found_q;
      mem_waddr_o = pick_q;
      mem_wdata_o = SIZE_BITS'(CMP_W'(pick_val_q) - CMP_W'(req_q));
    end
  end

  assign mem_raddr_o       = rd_idx_q[IDX_W-1:0];
  assign res_valid_o       = (state_q == ST_DONE);
  assign res_o.granted     = found_q;
  assign res_o.block_index = IDX_OUT_W'(pick_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_idx_q    <= '0;
      chk_valid_q <= 1'b0;
      chk_idx_q   <= '0;
      found_q     <= 1'b0;
      pick_q      <= '0;
      pick_val_q  <= '0;
      req_q       <= '0;
    end else begin
      chk_valid_q <= 1'b0;
      if (chk_valid_q && take) begin
        found_q    <= 1'b1;
        pick_q     <= chk_idx_q;
        pick_val_q <= mem_rdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (alloc_acc) begin
            req_q    <= in_if.size_value;
            found_q  <= 1'b0;
            pick_q   <= '0;
            rd_idx_q <= '0;
            state_q  <= (limit == '0) ? ST_DONE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          chk_valid_q <= 1'b1;
          chk_idx_q   <= rd_idx_q[IDX_W-1:0];
          rd_idx_q    <= rd_idx_q + LIM_W'(1);
          if (rd_idx_q == limit - LIM_W'(1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `FPBA_ASSERT(a_grant_in_range, clk_i, rst_ni, (res_valid_o && found_q) |-> (LIM_W'(pick_q) < limit), "granted block outside searched range")
  `FPBA_ASSERT(a_refuse_index_zero, clk_i, rst_ni, (res_valid_o && !found_q) |-> (pick_q == '0), "refused result with nonzero index")
  `FPBA_ASSERT(a_alloc_leaves_idle, clk_i, rst_ni, alloc_acc |=> (state_q != ST_IDLE), "allocate beat did not start a search")
  `FPBA_ASSERT_NEVER(a_scan_in_range, clk_i, rst_ni, (state_q == ST_SCAN) && (rd_idx_q >= limit), "scan read past block count")

endmodule

### sv/fit_policy_block_allocator_unit.sv
// Top level of the fit-policy block allocator.
// A load beat writes one block's capacity into the remaining-size table and returns nothing.
// An allocate beat is accepted in idle and then starts a scan of the table RAM. The scan does
// one synchronous read per searched block (block_count saturated at NUM_BLOCKS). A drain state
// covers the read latency. A last state writes the chosen entry back and hands the result to
// the output register; it waits there while the output register is still held by the
// downstream side. When block_count is zero the scan is skipped. The block takes no new beat
// until the allocate is done. The single RAM read port sets the length of the scan. The table
// comes out of reset as all zero through per-entry valid bits; there is no clearing pass. The
// user must write configuration only while idle; the block itself does not enforce it.
module fit_policy_block_allocator_unit #(
  parameter int unsigned NUM_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fpba_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data_i,
  fpba_in_if.sink                         in_if,
  fpba_out_if.source                      out_if
);
  import fpba_pkg::*;

  localparam int unsigned IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  // Configuration registers
  logic [POLICY_W-1:0]  policy_q;
  logic [COUNT_W-1:0]   bcount_q;

  // Output register: lets the sequencer take new beats while a result waits
  logic                 out_valid_q;
  result_t              out_res_q;

  // Sequencer to output stage
  logic                 res_valid;
  logic                 res_ready;
  result_t              res;

  // Table RAM port
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;
  logic [SIZE_BITS-1:0] mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_RESET;
      bcount_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_FIT_POLICY:  policy_q <= cfg_data_i[POLICY_W-1:0];
        REG_BLOCK_COUNT: bcount_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Result slot is free when empty or draining this cycle
  assign res_ready = !out_valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.granted     = out_res_q.granted;
  assign out_if.block_index = out_res_q.block_index;

  fpba_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .policy_i    (policy_q),
    .bcount_i    (bcount_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  fpba_ram #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH (SIZE_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
